### hdl/fmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_pkg: shared types and constants for the fraction multiply-reduce unit
// Holds the beat types of both channels and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fmr_pkg;

   // Width of each input operand (two's complement).
   localparam int OPERAND_WIDTH = 16;
   // Width of a signed product.
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   // Width of a product magnitude; the largest is 2**(PROD_WIDTH-2).
   localparam int MAG_WIDTH     = PROD_WIDTH - 1;
   // Width of each result field.
   localparam int OUT_WIDTH     = 32;
   // Width of the divider step counter.
   localparam int CNT_WIDTH     = $clog2(MAG_WIDTH);

   typedef struct packed {
      logic signed [OPERAND_WIDTH-1:0] first_numerator;
      logic signed [OPERAND_WIDTH-1:0] first_denominator;
      logic signed [OPERAND_WIDTH-1:0] second_numerator;
      logic signed [OPERAND_WIDTH-1:0] second_denominator;
   } req_data_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] out_numerator;
      logic signed [OUT_WIDTH-1:0] out_denominator;
      logic                        zero_denominator;
   } rsp_data_type;

   // How the result beat is formed.
   typedef enum logic [1:0] {
      KIND_REDUCED  = 2'd0,
      KIND_ZERO_NUM = 2'd1,
      KIND_ZERO_DEN = 2'd2
   } result_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load_in;    // capture the accepted request beat
      logic            mul_den;    // multiplier forms b*d instead of a*c
      logic            take_num;   // numerator magnitude and sign into x
      logic            take_den;   // denominator magnitude and sign into y
      logic            strip;      // drop a common factor of two
      logic            save;       // copy stripped magnitudes into the dividends
      logic            gcd_step;   // one binary GCD step
      logic            div_init;   // clear the divider remainders
      logic            div_step;   // one restoring division step
      logic            load_out;   // load the result register
      result_kind_type kind;       // result form for load_out
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic both_even;
   } status_type;

endpackage

### hdl/fmr_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_controller: sequencer for the fraction multiply-reduce unit
// Steps one item through multiply, zero tests, factor-of-two strip, GCD, division and result load.
// ----------------------------------------------------------------------------
module fmr_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fmr_pkg::status_type status,
   output fmr_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_MUL_NUM  = 9'b000000010,
      ST_MUL_DEN  = 9'b000000100,
      ST_TAKE_DEN = 9'b000001000,
      ST_TEST     = 9'b000010000,
      ST_STRIP    = 9'b000100000,
      ST_GCD      = 9'b001000000,
      ST_DIV      = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [fmr_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   fmr_pkg::result_kind_type        kind_ff, kind_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   localparam logic [fmr_pkg::CNT_WIDTH-1:0] CntLast =
      fmr_pkg::CNT_WIDTH'(fmr_pkg::MAG_WIDTH - 1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.kind     = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_NUM;
            end
         end
         ST_MUL_NUM: begin
            state_in    = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            cmd.mul_den  = 1'b1;
            cmd.take_num = 1'b1;
            state_in     = ST_TAKE_DEN;
         end
         ST_TAKE_DEN: begin
            cmd.take_den = 1'b1;
            state_in     = ST_TEST;
         end
         ST_TEST: begin
            if (status.y_zero) begin
               kind_in  = fmr_pkg::KIND_ZERO_DEN;
               state_in = ST_DONE;
            end else if (status.x_zero) begin
               kind_in  = fmr_pkg::KIND_ZERO_NUM;
               state_in = ST_DONE;
            end else begin
               kind_in  = fmr_pkg::KIND_REDUCED;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (status.both_even) begin
               cmd.strip = 1'b1;
            end else begin
               cmd.save = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.x_zero) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         kind_ff      <= fmr_pkg::KIND_REDUCED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/fmr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_datapath: arithmetic of the fraction multiply-reduce unit
// Shared multiplier, binary GCD registers, two restoring dividers, result register.
// ----------------------------------------------------------------------------
module fmr_datapath (
   input  logic                  clock,
   input  fmr_pkg::req_data_type req_data,
   input  fmr_pkg::cmd_type      cmd,
   output fmr_pkg::status_type   status,
   output fmr_pkg::rsp_data_type rsp_data
);

   localparam int MW = fmr_pkg::MAG_WIDTH;

   fmr_pkg::req_data_type               req_ff;
   logic signed [fmr_pkg::PROD_WIDTH-1:0] prod_ff;
   logic [MW-1:0]                       x_ff, y_ff;
   logic [MW-1:0]                       nn_ff, dd_ff;
   logic [MW-1:0]                       rn_ff, rd_ff;
   logic                                num_neg_ff, den_neg_ff;
   fmr_pkg::rsp_data_type               rsp_ff;

   logic signed [fmr_pkg::OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic signed [fmr_pkg::PROD_WIDTH-1:0]    product;
   logic [fmr_pkg::PROD_WIDTH-1:0]           prod_neg;
   logic [MW-1:0]                            prod_mag;
   logic [MW:0]                              x_minus_y, y_minus_x;
   logic [MW:0]                              rn_shift, rd_shift, rn_diff, rd_diff;
   logic [fmr_pkg::OUT_WIDTH-1:0]            q_num, q_den;

   // The one multiplier serves both products.
   assign mul_a   = cmd.mul_den ? req_ff.first_denominator  : req_ff.first_numerator;
   assign mul_b   = cmd.mul_den ? req_ff.second_denominator : req_ff.second_numerator;
   assign product = mul_a * mul_b;

   assign prod_neg = '0 - prod_ff;
   assign prod_mag = prod_ff[fmr_pkg::PROD_WIDTH-1] ? prod_neg[MW-1:0] : prod_ff[MW-1:0];

   assign x_minus_y = {1'b0, x_ff} - {1'b0, y_ff};
   assign y_minus_x = {1'b0, y_ff} - {1'b0, x_ff};

   assign rn_shift = {rn_ff, nn_ff[MW-1]};
   assign rd_shift = {rd_ff, dd_ff[MW-1]};
   assign rn_diff  = rn_shift - {1'b0, y_ff};
   assign rd_diff  = rd_shift - {1'b0, y_ff};

   assign q_num = fmr_pkg::OUT_WIDTH'({1'b0, nn_ff});
   assign q_den = fmr_pkg::OUT_WIDTH'({1'b0, dd_ff});

   always_ff @(posedge clock) begin
      prod_ff <= product;
      if (cmd.load_in) begin
         req_ff <= req_data;
      end
      if (cmd.take_num) begin
         x_ff       <= prod_mag;
         num_neg_ff <= prod_ff[fmr_pkg::PROD_WIDTH-1];
      end
      if (cmd.take_den) begin
         y_ff       <= prod_mag;
         den_neg_ff <= prod_ff[fmr_pkg::PROD_WIDTH-1];
      end
      if (cmd.strip) begin
         x_ff <= x_ff >> 1;
         y_ff <= y_ff >> 1;
      end
      if (cmd.save) begin
         nn_ff <= x_ff;
         dd_ff <= y_ff;
      end
      // Binary GCD: halve an even value, else halve the difference of two odd ones.
      if (cmd.gcd_step) begin
         if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (!x_minus_y[MW]) begin
            x_ff <= {1'b0, x_minus_y[MW-1:1]};
         end else begin
            y_ff <= {1'b0, y_minus_x[MW-1:1]};
         end
      end
      if (cmd.div_init) begin
         rn_ff <= '0;
         rd_ff <= '0;
      end
      // Restoring division by the GCD; each dividend register fills with its quotient.
      if (cmd.div_step) begin
         rn_ff <= rn_diff[MW] ? rn_shift[MW-1:0] : rn_diff[MW-1:0];
         rd_ff <= rd_diff[MW] ? rd_shift[MW-1:0] : rd_diff[MW-1:0];
         nn_ff <= {nn_ff[MW-2:0], !rn_diff[MW]};
         dd_ff <= {dd_ff[MW-2:0], !rd_diff[MW]};
      end
      if (cmd.load_out) begin
         case (cmd.kind)
            fmr_pkg::KIND_ZERO_DEN: begin
               rsp_ff.out_numerator    <= '0;
               rsp_ff.out_denominator  <= '0;
               rsp_ff.zero_denominator <= 1'b1;
            end
            fmr_pkg::KIND_ZERO_NUM: begin
               rsp_ff.out_numerator    <= '0;
               rsp_ff.out_denominator  <= fmr_pkg::OUT_WIDTH'(1);
               rsp_ff.zero_denominator <= 1'b0;
            end
            default: begin
               rsp_ff.out_numerator    <= num_neg_ff ? ('0 - q_num) : q_num;
               rsp_ff.out_denominator  <= den_neg_ff ? ('0 - q_den) : q_den;
               rsp_ff.zero_denominator <= 1'b0;
            end
         endcase
      end
   end

   assign status.x_zero    = (x_ff == '0);
   assign status.y_zero    = (y_ff == '0);
   assign status.both_even = !x_ff[0] && !y_ff[0];
   assign rsp_data         = rsp_ff;

endmodule

### hdl/fraction_multiply_reduce_unit.sv
`timescale 1ns / 1ps
// One item at a time; the next request beat can be taken in the cycle after the
// result is loaded. The time goes to the one-step-per-cycle strip and binary GCD loops and
// the bit-serial dividers.
// A new request beat is taken while the previous result beat still waits.
// Reset is synchronous and active high; it idles the sequencer and drops rsp_valid.
// ----------------------------------------------------------------------------
// fraction_multiply_reduce_unit: multiply two signed fractions, reduce to lowest terms
// Forms a*c and b*d, divides both by the GCD of their magnitudes, keeps each sign.
// ----------------------------------------------------------------------------
module fraction_multiply_reduce_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fmr_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fmr_pkg::rsp_data_type rsp_data
);

   // The controller sequences the work; the datapath holds every operand register.
   // They talk only through the command and status structs below.
   fmr_pkg::cmd_type    cmd;
   fmr_pkg::status_type status;

   // Flow per item: capture the beat, both products in turn on the one multiplier,
   // magnitudes and signs split off, zero tests (a zero denominator wins over a
   // zero numerator), common factors of two stripped, binary GCD on the odd rest,
   // then both stripped magnitudes are divided exactly by the odd GCD part.
   fmr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result register in the datapath parts the two channels, so the next
   // item can run while this result beat is held for the consumer.
   fmr_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### hdl/fmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_checker: port-level checks for the fraction multiply-reduce unit
// Watches the handshakes and the special-case result encodings.
// ----------------------------------------------------------------------------
module fmr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input fmr_pkg::rsp_data_type rsp_data
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // One item at a time: the request side closes right after a beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in flight");

   // A zero denominator forces both result values to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.out_numerator == '0 && rsp_data.out_denominator == '0)
      else $error("zero denominator beat carries nonzero values");

   // A zero numerator reduces to zero over one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_denominator && rsp_data.out_numerator == '0 |->
         rsp_data.out_denominator == fmr_pkg::OUT_WIDTH'(1))
      else $error("zero numerator not reduced to one denominator");

   // Reset drops the result valid.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fraction_multiply_reduce_unit fmr_checker u_fmr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/fraction_product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_product_checker: scoreboard for the fraction multiply-reduce unit
// Watches both channels, predicts each reduced product and compares results.
// ----------------------------------------------------------------------------
module fraction_product_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  fmr_pkg::req_data_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  fmr_pkg::rsp_data_type rsp_data,
   output int                    error_count,
   output int                    pending_count,
   output int                    reduced_count,
   output int                    zero_num_count,
   output int                    zero_den_count
);

   fmr_pkg::rsp_data_type expected_reductions[$];
   int                    errors     = 0;
   int                    reduced    = 0;
   int                    zero_nums  = 0;
   int                    zero_dens  = 0;

   // Product a*c over b*d, both divided by the GCD of their magnitudes.
   function automatic fmr_pkg::rsp_data_type reduce_product(
      input fmr_pkg::req_data_type beat);
      longint                num;
      longint                den;
      longint                x;
      longint                y;
      longint                t;
      fmr_pkg::rsp_data_type r;
      num = longint'($signed(beat.first_numerator)) *
            longint'($signed(beat.second_numerator));
      den = longint'($signed(beat.first_denominator)) *
            longint'($signed(beat.second_denominator));
      r = '0;
      if (den == 0) begin
         r.zero_denominator = 1'b1;
      end else if (num == 0) begin
         r.out_denominator = fmr_pkg::OUT_WIDTH'(1);
      end else begin
         x = (num < 0) ? -num : num;
         y = (den < 0) ? -den : den;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         // The division is exact, so truncation keeps each sign as it is.
         r.out_numerator   = fmr_pkg::OUT_WIDTH'(num / x);
         r.out_denominator = fmr_pkg::OUT_WIDTH'(den / x);
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      fmr_pkg::rsp_data_type want;
      if (!reset) begin
         // Results are retired before requests are queued: a result can never
         // belong to a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_reductions.size() == 0) begin
               $error("result beat with no expectation waiting: %0d / %0d, flag %0b",
                      rsp_data.out_numerator, rsp_data.out_denominator,
                      rsp_data.zero_denominator);
               errors++;
            end else begin
               want = expected_reductions.pop_front();
               if (rsp_data.out_numerator !== want.out_numerator) begin
                  $error("out_numerator: expected %0d, got %0d",
                         want.out_numerator, rsp_data.out_numerator);
                  errors++;
               end
               if (rsp_data.out_denominator !== want.out_denominator) begin
                  $error("out_denominator: expected %0d, got %0d",
                         want.out_denominator, rsp_data.out_denominator);
                  errors++;
               end
               if (rsp_data.zero_denominator !== want.zero_denominator) begin
                  $error("zero_denominator: expected %0b, got %0b",
                         want.zero_denominator, rsp_data.zero_denominator);
                  errors++;
               end
               if (want.zero_denominator) begin
                  zero_dens++;
               end else if (want.out_numerator == 0) begin
                  zero_nums++;
               end else begin
                  reduced++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_reductions.push_back(reduce_product(req_data));
         end
      end
      error_count    <= errors;
      pending_count  <= expected_reductions.size();
      reduced_count  <= reduced;
      zero_num_count <= zero_nums;
      zero_den_count <= zero_dens;
   end

endmodule

### bench/fraction_multiply_reduce_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_multiply_reduce_unit_tb: testbench for the fraction multiply-reduce unit
// Drives directed and random fraction pairs under varying idle patterns and a
// long output stall; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module fraction_multiply_reduce_unit_tb;

   // The drain runs well past the slowest item, so it is ample to catch any
   // stray result beat after the last result.
   localparam int DRAIN_CYCLES = 300;
   // Far above the slowest correct run of roughly 670 items, including stalls
   // and the long hold-off.
   localparam int CYCLE_LIMIT  = 1000000;
   // Length of the long hold-off on the result channel.
   localparam int HOLD_CYCLES  = 400;

   localparam int MOST_POS = (1 << (fmr_pkg::OPERAND_WIDTH - 1)) - 1;
   localparam int MOST_NEG = -(1 << (fmr_pkg::OPERAND_WIDTH - 1));

   // How one operand of a random beat is drawn.
   typedef enum int unsigned {
      FLAVOR_FULL  = 0,   // any value of the field
      FLAVOR_SMALL = 1,   // small magnitudes, many common factors and zeros
      FLAVOR_EDGE  = 2,   // extremes of the field
      FLAVOR_POWER = 3    // signed powers of two
   } operand_flavor_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   fmr_pkg::req_data_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   fmr_pkg::rsp_data_type rsp_data;

   int error_count;
   int pending_count;
   int reduced_count;
   int zero_num_count;
   int zero_den_count;

   // Idle rates of the two sides in percent, changed between phases.
   int unsigned req_idle_pct = 15;
   int unsigned rsp_idle_pct = 63;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit          hold_request = 1'b0;
   // Set by the receiver once that hold-off has started.
   bit          hold_done    = 1'b0;
   int          hold_left    = 0;
   int          cycle_count  = 0;

   fraction_multiply_reduce_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fraction_product_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .reduced_count  (reduced_count),
      .zero_num_count (zero_num_count),
      .zero_den_count (zero_den_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver. The long hold-off is counted here, independent of the sender,
   // so the sender keeps offering beats while results back up; the block then
   // holds one finished result and one item in work and drops req_ready.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic fmr_pkg::req_data_type make_beat(input int a, input int b,
                                                       input int c, input int d);
      fmr_pkg::req_data_type beat;
      beat.first_numerator    = fmr_pkg::OPERAND_WIDTH'(a);
      beat.first_denominator  = fmr_pkg::OPERAND_WIDTH'(b);
      beat.second_numerator   = fmr_pkg::OPERAND_WIDTH'(c);
      beat.second_denominator = fmr_pkg::OPERAND_WIDTH'(d);
      return beat;
   endfunction

   function automatic int pick_operand(input operand_flavor_type flavor);
      int v;
      case (flavor)
         FLAVOR_SMALL: begin
            v = int'($urandom_range(40)) - 20;
         end
         FLAVOR_EDGE: begin
            case ($urandom_range(6))
               0:       v = MOST_NEG;
               1:       v = MOST_POS;
               2:       v = -1;
               3:       v = 0;
               4:       v = 1;
               5:       v = MOST_NEG + 1;
               default: v = 1 << (fmr_pkg::OPERAND_WIDTH - 2);
            endcase
         end
         FLAVOR_POWER: begin
            v = 1 << $urandom_range(fmr_pkg::OPERAND_WIDTH - 2);
            if ($urandom_range(1) == 1) begin
               v = -v;
            end
         end
         default: begin
            v = int'($urandom_range((1 << fmr_pkg::OPERAND_WIDTH) - 1)) + MOST_NEG;
         end
      endcase
      return v;
   endfunction

   // A random multiple of g that still fits the operand field.
   function automatic int multiple_of(input int g);
      int lim;
      lim = MOST_POS / g;
      return g * (int'($urandom_range(2 * lim)) - lim);
   endfunction

   function automatic fmr_pkg::req_data_type random_fractions();
      fmr_pkg::req_data_type beat;
      int                    g;
      int                    h;
      beat = make_beat(pick_operand(operand_flavor_type'($urandom_range(3))),
                       pick_operand(operand_flavor_type'($urandom_range(3))),
                       pick_operand(operand_flavor_type'($urandom_range(3))),
                       pick_operand(operand_flavor_type'($urandom_range(3))));
      case ($urandom_range(9))
         0, 1, 2: begin
            // Cross factors: a with d and c with b, so the GCD is large.
            g = $urandom_range(2, 200);
            h = $urandom_range(2, 200);
            beat = make_beat(multiple_of(g), multiple_of(h),
                             multiple_of(h), multiple_of(g));
         end
         3, 4: begin
            // Plain reduction of a single fraction: times one over one.
            g = $urandom_range(1, 500);
            beat = make_beat(multiple_of(g), multiple_of(g), 1, 1);
         end
         5: begin
            case ($urandom_range(3))
               0:       beat.first_numerator    = '0;
               1:       beat.first_denominator  = '0;
               2:       beat.second_numerator   = '0;
               default: beat.second_denominator = '0;
            endcase
         end
         default: begin
            // All four operands of the same flavor.
            g = $urandom_range(3);
            beat = make_beat(pick_operand(operand_flavor_type'(g)),
                             pick_operand(operand_flavor_type'(g)),
                             pick_operand(operand_flavor_type'(g)),
                             pick_operand(operand_flavor_type'(g)));
         end
      endcase
      return beat;
   endfunction

   // Offers one beat, with random idle cycles before it, and returns at the
   // edge where it is taken. Valid is only lowered when an idle cycle follows,
   // so back-to-back beats keep it high.
   task automatic offer_fractions(input fmr_pkg::req_data_type beat);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (11) @(posedge clock);
      reset     <= 1'b0;

      // Directed beats: zero products, every sign combination, operand extremes.
      offer_fractions(make_beat(0, 1, 0, 1));            // zero numerator
      offer_fractions(make_beat(1, 0, 1, 1));            // zero denominator
      offer_fractions(make_beat(0, 0, 0, 0));            // both products zero
      offer_fractions(make_beat(5, 7, 3, 0));            // zero from second fraction
      offer_fractions(make_beat(0, MOST_NEG, 5, 7));     // zero numerator, big den
      offer_fractions(make_beat(3, 4, 2, 3));
      offer_fractions(make_beat(-3, 4, 2, 3));
      offer_fractions(make_beat(3, -4, 2, 3));           // negative denominator kept
      offer_fractions(make_beat(-3, -4, 2, 3));
      offer_fractions(make_beat(6, 8, 1, 1));            // plain reduction
      offer_fractions(make_beat(-6, 8, 1, 1));
      offer_fractions(make_beat(1, 1, 1, 1));
      offer_fractions(make_beat(-1, -1, -1, -1));
      offer_fractions(make_beat(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
      offer_fractions(make_beat(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS));
      offer_fractions(make_beat(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG));
      offer_fractions(make_beat(MOST_NEG, 1, MOST_POS, 1));
      offer_fractions(make_beat(1, MOST_NEG, 1, MOST_POS));
      offer_fractions(make_beat(MOST_POS, MOST_POS, MOST_POS, MOST_POS));
      offer_fractions(make_beat(32749, 32719, 32717, 32713)); // coprime primes
      offer_fractions(make_beat(16384, -8192, 4096, 2));      // powers of two
      offer_fractions(make_beat(12345, -30000, -20000, 11111));
      offer_fractions(make_beat(7, 7, 0, 0));

      // Sender idles little, receiver idles most of the time.
      repeat (220) offer_fractions(random_fractions());

      // The other way round: the block mostly waits for work.
      req_idle_pct = 63;
      rsp_idle_pct = 15;
      repeat (210) offer_fractions(random_fractions());

      // No idling at all, opened by one long hold-off on the result side.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 1'b1;
      repeat (220) offer_fractions(random_fractions());
      req_valid <= 1'b0;

      // The first sample after the last beat already counts that beat.
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d reduced products, %0d zero numerators, %0d zero denominators",
               reduced_count, zero_num_count, zero_den_count);
      $display("under three idle mixes and a %0d-cycle stall of the result channel.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
